// ----- hw/rtl/rcc_pkg.sv -----
// rcc_pkg: shared types and constants for the rectangle clip classifier
// no dependencies; used by rcc_window_regs, rcc_axis and the top level
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int CODE_W = 3;
    localparam int CUT_W = 16;
    localparam int SPAN_W = 15;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_LOW = 3'd1;
    localparam logic [CODE_W-1:0] CODE_HIGH = 3'd2;
    localparam logic [CODE_W-1:0] CODE_BOTH = 3'd3;
    localparam logic [CODE_W-1:0] CODE_INVISIBLE = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 2'd3;

    localparam int RESET_LEFT = 0;
    localparam int RESET_RIGHT = 800;
    localparam int RESET_TOP = 0;
    localparam int RESET_BOTTOM = 600;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CUT_W-1:0]  cut_lo;
        logic [CUT_W-1:0]  cut_hi;
        logic [SPAN_W-1:0] span;
    } axis_result_t;

endpackage

// ----- hw/rtl/rectangle_clip_classifier.sv -----
// rectangle_clip_classifier: clips a rectangle against the clip window per axis
// depends on rcc_pkg, rcc_window_regs and rcc_axis
// start and the rect inputs pass one input register stage, the axis compares and one result register to done
// throughput: one transaction per cycle; busy stays low, start is taken every cycle
// done is high for exactly one cycle per transaction; the receiver cannot stall
// reset: window registers to left 0, right 800, top 0, bottom 600; pipeline empties
`timescale 1ns / 1ps

module rectangle_clip_classifier #(
    parameter int COORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic signed [COORD_BITS-1:0]       cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       rect_x,
    input  logic signed [COORD_BITS-1:0]       rect_y,
    input  logic signed [COORD_BITS-1:0]       rect_width,
    input  logic signed [COORD_BITS-1:0]       rect_height,
    output logic                               done,
    output logic [rcc_pkg::CODE_W-1:0]         horiz_code,
    output logic [rcc_pkg::CODE_W-1:0]         vert_code,
    output logic [rcc_pkg::CUT_W-1:0]          left_cut,
    output logic [rcc_pkg::CUT_W-1:0]          right_cut,
    output logic [rcc_pkg::CUT_W-1:0]          top_cut,
    output logic [rcc_pkg::CUT_W-1:0]          bottom_cut,
    output logic [rcc_pkg::SPAN_W-1:0]         visible_width,
    output logic [rcc_pkg::SPAN_W-1:0]         visible_height,
    output logic                               is_visible
);

    logic signed [COORD_BITS-1:0] window_left;
    logic signed [COORD_BITS-1:0] window_right;
    logic signed [COORD_BITS-1:0] window_top;
    logic signed [COORD_BITS-1:0] window_bottom;

    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] width_reg;
    logic signed [COORD_BITS-1:0] height_reg;

    rcc_pkg::axis_result_t        horiz_next;
    rcc_pkg::axis_result_t        vert_next;
    rcc_pkg::axis_result_t        horiz_reg;
    rcc_pkg::axis_result_t        vert_reg;
    logic                         done_reg;
    logic                         visible_next;
    logic                         visible_reg;

    assign busy = 1'b0;

    rcc_window_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_window_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .window_left   (window_left),
        .window_right  (window_right),
        .window_top    (window_top),
        .window_bottom (window_bottom)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            x_reg <= rect_x;
            y_reg <= rect_y;
            width_reg <= rect_width;
            height_reg <= rect_height;
        end
    end

    rcc_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_horiz (
        .pos    (x_reg),
        .size   (width_reg),
        .lo     (window_left),
        .hi     (window_right),
        .result (horiz_next)
    );

    rcc_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_vert (
        .pos    (y_reg),
        .size   (height_reg),
        .lo     (window_top),
        .hi     (window_bottom),
        .result (vert_next)
    );

    assign visible_next = (horiz_next.code != rcc_pkg::CODE_INVISIBLE)
                       && (vert_next.code != rcc_pkg::CODE_INVISIBLE);

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            horiz_reg <= horiz_next;
            vert_reg <= vert_next;
            visible_reg <= visible_next;
        end
    end

    assign done = done_reg;
    assign horiz_code = horiz_reg.code;
    assign vert_code = vert_reg.code;
    assign left_cut = horiz_reg.cut_lo;
    assign right_cut = horiz_reg.cut_hi;
    assign top_cut = vert_reg.cut_lo;
    assign bottom_cut = vert_reg.cut_hi;
    assign visible_width = horiz_reg.span;
    assign visible_height = vert_reg.span;
    assign is_visible = visible_reg;

endmodule

// ----- hw/rtl/rcc_window_regs.sv -----
// rcc_window_regs: the four clip window registers and their write port
// depends on rcc_pkg for register indexes and reset values
`timescale 1ns / 1ps

module rcc_window_regs #(
    parameter int COORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic signed [COORD_BITS-1:0]       cfg_data,
    output logic signed [COORD_BITS-1:0]       window_left,
    output logic signed [COORD_BITS-1:0]       window_right,
    output logic signed [COORD_BITS-1:0]       window_top,
    output logic signed [COORD_BITS-1:0]       window_bottom
);

    logic signed [COORD_BITS-1:0] left_reg;
    logic signed [COORD_BITS-1:0] right_reg;
    logic signed [COORD_BITS-1:0] top_reg;
    logic signed [COORD_BITS-1:0] bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= COORD_BITS'(rcc_pkg::RESET_LEFT);
            right_reg <= COORD_BITS'(rcc_pkg::RESET_RIGHT);
            top_reg <= COORD_BITS'(rcc_pkg::RESET_TOP);
            bottom_reg <= COORD_BITS'(rcc_pkg::RESET_BOTTOM);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rcc_pkg::REG_WINDOW_LEFT:   left_reg <= cfg_data;
                rcc_pkg::REG_WINDOW_RIGHT:  right_reg <= cfg_data;
                rcc_pkg::REG_WINDOW_TOP:    top_reg <= cfg_data;
                rcc_pkg::REG_WINDOW_BOTTOM: bottom_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign window_left = left_reg;
    assign window_right = right_reg;
    assign window_top = top_reg;
    assign window_bottom = bottom_reg;

endmodule

// ----- hw/rtl/rcc_axis.sv -----
// rcc_axis: combinational clip of one axis against a window span
// depends on rcc_pkg for clip codes and the result struct
`timescale 1ns / 1ps

module rcc_axis #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] pos,
    input  logic signed [COORD_BITS-1:0] size,
    input  logic signed [COORD_BITS-1:0] lo,
    input  logic signed [COORD_BITS-1:0] hi,
    output rcc_pkg::axis_result_t        result
);

    // room for pos + size - hi without wrap, and at least a full cut field
    localparam int EW = (COORD_BITS + 2 > rcc_pkg::CUT_W) ? COORD_BITS + 2 : rcc_pkg::CUT_W;

    logic signed [EW-1:0] pos_x;
    logic signed [EW-1:0] size_x;
    logic signed [EW-1:0] lo_x;
    logic signed [EW-1:0] hi_x;
    logic signed [EW-1:0] end_x;
    logic signed [EW-1:0] clo;
    logic signed [EW-1:0] chi;
    logic signed [EW-1:0] span_x;
    logic                 invisible;
    logic                 cut_low;
    logic                 cut_high;

    assign pos_x = EW'(pos);
    assign size_x = EW'(size);
    assign lo_x = EW'(lo);
    assign hi_x = EW'(hi);
    assign end_x = pos_x + size_x;

    assign invisible = (size_x <= 0) || (end_x <= lo_x) || (pos_x >= hi_x);
    assign cut_low = pos_x < lo_x;
    assign cut_high = end_x > hi_x;

    assign clo = cut_low ? (lo_x - pos_x) : '0;
    assign chi = cut_high ? (end_x - hi_x) : '0;
    assign span_x = size_x - clo - chi;

    always_comb
    begin
        result.code = rcc_pkg::CODE_NONE;
        result.cut_lo = clo[rcc_pkg::CUT_W-1:0];
        result.cut_hi = chi[rcc_pkg::CUT_W-1:0];
        result.span = span_x[rcc_pkg::SPAN_W-1:0];
        if (invisible)
        begin
            result.code = rcc_pkg::CODE_INVISIBLE;
            result.cut_lo = '0;
            result.cut_hi = '0;
            result.span = '0;
        end
        else if (cut_low && cut_high)
        begin
            result.code = rcc_pkg::CODE_BOTH;
        end
        else if (cut_low)
        begin
            result.code = rcc_pkg::CODE_LOW;
        end
        else if (cut_high)
        begin
            result.code = rcc_pkg::CODE_HIGH;
        end
    end

endmodule
